// ----- rtl/core/c_subset_token_scanner_unit_defines.svh -----
// Assertion macros shared by the token scanner RTL.
`ifndef C_SUBSET_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define C_SUBSET_TOKEN_SCANNER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CTSU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define CTSU_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define CTSU_ASSERT(label, clk, rst_n, prop)
`define CTSU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/ctsu_pkg.sv -----
// Types, token codes and character class functions of the token scanner.
package ctsu_pkg;

	localparam int TOKEN_KIND_BITS   = 5;
	localparam int TOKEN_START_BITS  = 32;
	localparam int TOKEN_LENGTH_BITS = 16;
	localparam int KEYWORD_MAX_LEN   = 6;
	localparam int FIFO_DEPTH        = 4;
	localparam int FIFO_PTR_BITS     = 2;
	localparam int FIFO_COUNT_BITS   = 3;

	typedef logic [TOKEN_KIND_BITS-1:0] kind_t;

	localparam kind_t KIND_EOF     = 5'd0;
	localparam kind_t KIND_INTEGER = 5'd1;
	localparam kind_t KIND_IDENT   = 5'd2;
	localparam kind_t KIND_GT      = 5'd3;
	localparam kind_t KIND_LT      = 5'd4;
	localparam kind_t KIND_GE      = 5'd5;
	localparam kind_t KIND_LE      = 5'd6;
	localparam kind_t KIND_EQ      = 5'd7;
	localparam kind_t KIND_NE      = 5'd8;
	localparam kind_t KIND_PLUS    = 5'd9;
	localparam kind_t KIND_MINUS   = 5'd10;
	localparam kind_t KIND_STAR    = 5'd11;
	localparam kind_t KIND_SLASH   = 5'd12;
	localparam kind_t KIND_LPAREN  = 5'd13;
	localparam kind_t KIND_RPAREN  = 5'd14;
	localparam kind_t KIND_LBRACE  = 5'd15;
	localparam kind_t KIND_RBRACE  = 5'd16;
	localparam kind_t KIND_SEMI    = 5'd17;
	localparam kind_t KIND_COMMA   = 5'd18;
	localparam kind_t KIND_IF      = 5'd19;
	localparam kind_t KIND_ELSE    = 5'd20;
	localparam kind_t KIND_WHILE   = 5'd21;
	localparam kind_t KIND_INT     = 5'd22;
	localparam kind_t KIND_RETURN  = 5'd23;
	localparam kind_t KIND_ERROR   = 5'd24;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_GT,
		MODE_LT,
		MODE_BANG,
		MODE_ERR
	} mode_t;

	typedef struct packed {
		logic                  valid;
		logic [7:0]            char_code;
		logic                  end_of_text;
	} item_t;

	typedef struct packed {
		kind_t                        kind;
		logic [TOKEN_START_BITS-1:0]  start;
		logic [TOKEN_LENGTH_BITS-1:0] length;
	} token_t;

	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} emit_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} fifo_entry_t;

	typedef logic [KEYWORD_MAX_LEN-1:0][7:0] kw_window_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "z")) ||
			((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// {hit, kind} for one-character operators and punctuation
	function automatic logic [TOKEN_KIND_BITS:0] single_kind(input logic [7:0] c);
		logic [TOKEN_KIND_BITS:0] r;
		r = {1'b1, KIND_ERROR};
		case (c)
			"=": r = {1'b1, KIND_EQ};
			"+": r = {1'b1, KIND_PLUS};
			"-": r = {1'b1, KIND_MINUS};
			"*": r = {1'b1, KIND_STAR};
			"/": r = {1'b1, KIND_SLASH};
			"(": r = {1'b1, KIND_LPAREN};
			")": r = {1'b1, KIND_RPAREN};
			"{": r = {1'b1, KIND_LBRACE};
			"}": r = {1'b1, KIND_RBRACE};
			";": r = {1'b1, KIND_SEMI};
			",": r = {1'b1, KIND_COMMA};
			default: r = {1'b0, KIND_ERROR};
		endcase
		return r;
	endfunction

	// len is the lexeme length clipped to 7
	function automatic kind_t keyword_kind(input kw_window_t w, input logic [2:0] len);
		kind_t k;
		k = KIND_IDENT;
		priority if (len == 3'd2 && w[0] == "i" && w[1] == "f")
			k = KIND_IF;
		else if (len == 3'd4 && w[0] == "e" && w[1] == "l" && w[2] == "s" && w[3] == "e")
			k = KIND_ELSE;
		else if (len == 3'd5 && w[0] == "w" && w[1] == "h" && w[2] == "i" &&
				w[3] == "l" && w[4] == "e")
			k = KIND_WHILE;
		else if (len == 3'd3 && w[0] == "i" && w[1] == "n" && w[2] == "t")
			k = KIND_INT;
		else if (len == 3'd6 && w[0] == "r" && w[1] == "e" && w[2] == "t" &&
				w[3] == "u" && w[4] == "r" && w[5] == "n")
			k = KIND_RETURN;
		else
			k = KIND_IDENT;
		return k;
	endfunction

endpackage

// ----- rtl/core/ctsu_scan.sv -----
// Scanner state machine: consumes one character request and emits up to two tokens.
module ctsu_scan #(
	parameter int POSITION_BITS = 32,
	parameter int LENGTH_BITS   = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ctsu_pkg::item_t item,
	output ctsu_pkg::emit_t emit
);
	import ctsu_pkg::*;

	localparam int IDX_BITS = $clog2(KEYWORD_CHARS);

	mode_t                    mode_q, mode_d, fresh_mode;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] pstart_q, pstart_d;
	logic [LENGTH_BITS-1:0]   plen_q, plen_d;
	logic                     digits_q, digits_d;
	logic [7:0]               window_q [KEYWORD_CHARS];

	logic                     win_we;
	logic [IDX_BITS-1:0]      win_idx;
	logic                     take_fresh;

	logic [7:0]               c;
	logic                     c_word, c_digit, c_space, c_gt, c_lt, c_bang, c_eq;
	logic [TOKEN_KIND_BITS:0] c_single;
	logic                     c_unknown;

	kw_window_t               kw_win;
	logic [2:0]               len_code;
	token_t                   word_tok, fresh_tok, pend_tok, sec_tok;
	logic                     fresh_v, pend_v, sec_v;

	assign c         = item.char_code;
	assign c_word    = is_word(c);
	assign c_digit   = is_digit(c);
	assign c_space   = is_space(c);
	assign c_gt      = (c == ">");
	assign c_lt      = (c == "<");
	assign c_bang    = (c == "!");
	assign c_eq      = (c == "=");
	assign c_single  = single_kind(c);
	assign c_unknown = !(c_space || c_word || c_gt || c_lt || c_bang || c_single[TOKEN_KIND_BITS]);

	always_comb begin
		priority if (c_space)
			fresh_mode = MODE_IDLE;
		else if (c_word)
			fresh_mode = MODE_WORD;
		else if (c_gt)
			fresh_mode = MODE_GT;
		else if (c_lt)
			fresh_mode = MODE_LT;
		else if (c_bang)
			fresh_mode = MODE_BANG;
		else if (c_single[TOKEN_KIND_BITS])
			fresh_mode = MODE_IDLE;
		else
			fresh_mode = MODE_ERR;
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		pos_d      = pos_q;
		pstart_d   = pstart_q;
		plen_d     = plen_q;
		digits_d   = digits_q;
		win_we     = 1'b0;
		win_idx    = plen_q[IDX_BITS-1:0];
		take_fresh = 1'b0;
		if (item.valid) begin
			if (item.end_of_text) begin
				mode_d   = MODE_IDLE;
				pos_d    = '0;
				pstart_d = '0;
				plen_d   = '0;
				digits_d = 1'b1;
			end else begin
				pos_d = pos_q + 1'b1;
				unique case (mode_q)
					MODE_IDLE: take_fresh = 1'b1;
					MODE_WORD: begin
						if (c_word) begin
							win_we = (32'(plen_q) < KEYWORD_CHARS);
							if (plen_q != '1)
								plen_d = plen_q + 1'b1;
							if (!c_digit)
								digits_d = 1'b0;
						end else begin
							take_fresh = 1'b1;
						end
					end
					MODE_GT, MODE_LT: begin
						if (c_eq)
							mode_d = MODE_IDLE;
						else
							take_fresh = 1'b1;
					end
					MODE_BANG: mode_d = c_eq ? MODE_IDLE : MODE_ERR;
					MODE_ERR:  mode_d = MODE_ERR;
					default:   mode_d = MODE_IDLE;
				endcase
				if (take_fresh) begin
					mode_d = fresh_mode;
					if (c_word || c_gt || c_lt || c_bang) begin
						pstart_d = pos_q;
						plen_d   = LENGTH_BITS'(1);
					end
					if (c_word) begin
						digits_d = c_digit;
						win_we   = 1'b1;
						win_idx  = '0;
					end
				end
			end
		end
	end

	// outputs
	always_comb begin
		for (int i = 0; i < KEYWORD_MAX_LEN; i++)
			kw_win[i] = window_q[i];
		len_code = (plen_q > LENGTH_BITS'(KEYWORD_MAX_LEN)) ? 3'd7 : plen_q[2:0];

		word_tok.kind   = digits_q ? KIND_INTEGER : keyword_kind(kw_win, len_code);
		word_tok.start  = TOKEN_START_BITS'(pstart_q);
		word_tok.length = TOKEN_LENGTH_BITS'(plen_q);

		fresh_v          = c_single[TOKEN_KIND_BITS] || c_unknown;
		fresh_tok.kind   = c_single[TOKEN_KIND_BITS] ? c_single[TOKEN_KIND_BITS-1:0] : KIND_ERROR;
		fresh_tok.start  = TOKEN_START_BITS'(pos_q);
		fresh_tok.length = TOKEN_LENGTH_BITS'(1);

		pend_v          = 1'b0;
		pend_tok        = word_tok;
		sec_v           = 1'b0;
		sec_tok         = fresh_tok;

		if (item.valid) begin
			if (item.end_of_text) begin
				sec_v          = 1'b1;
				sec_tok.kind   = KIND_EOF;
				sec_tok.start  = TOKEN_START_BITS'(pos_q);
				sec_tok.length = '0;
				pend_tok.length = TOKEN_LENGTH_BITS'(1);
				unique case (mode_q)
					MODE_WORD: begin
						pend_v   = 1'b1;
						pend_tok = word_tok;
					end
					MODE_GT: begin
						pend_v        = 1'b1;
						pend_tok.kind = KIND_GT;
					end
					MODE_LT: begin
						pend_v        = 1'b1;
						pend_tok.kind = KIND_LT;
					end
					MODE_BANG: begin
						pend_v        = 1'b1;
						pend_tok.kind = KIND_ERROR;
					end
					default: pend_v = 1'b0;
				endcase
			end else begin
				unique case (mode_q)
					MODE_IDLE: sec_v = fresh_v;
					MODE_WORD: begin
						if (!c_word) begin
							pend_v = 1'b1;
							sec_v  = fresh_v;
						end
					end
					MODE_GT, MODE_LT: begin
						pend_v = 1'b1;
						if (c_eq) begin
							pend_tok.kind   = (mode_q == MODE_GT) ? KIND_GE : KIND_LE;
							pend_tok.length = TOKEN_LENGTH_BITS'(2);
						end else begin
							pend_tok.kind   = (mode_q == MODE_GT) ? KIND_GT : KIND_LT;
							pend_tok.length = TOKEN_LENGTH_BITS'(1);
							sec_v           = fresh_v;
						end
					end
					MODE_BANG: begin
						pend_v          = 1'b1;
						pend_tok.kind   = c_eq ? KIND_NE : KIND_ERROR;
						pend_tok.length = c_eq ? TOKEN_LENGTH_BITS'(2) : TOKEN_LENGTH_BITS'(1);
					end
					default: pend_v = 1'b0;
				endcase
			end
		end

		if (pend_v) begin
			emit.v0 = 1'b1;
			emit.t0 = pend_tok;
			emit.v1 = sec_v;
			emit.t1 = sec_tok;
		end else begin
			emit.v0 = sec_v;
			emit.t0 = sec_tok;
			emit.v1 = 1'b0;
			emit.t1 = sec_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			digits_q <= 1'b1;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			digits_q <= digits_d;
		end
	end

	always_ff @(posedge clk) begin
		if (win_we)
			window_q[win_idx] <= c;
	end

endmodule

// ----- rtl/core/ctsu_fifo.sv -----
// Token output queue: takes up to two tokens per cycle, presents one at a time.
`include "c_subset_token_scanner_unit_defines.svh"
module ctsu_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctsu_pkg::emit_t       push,
	input  logic                  stall,
	output logic                  valid,
	output ctsu_pkg::fifo_entry_t head,
	output logic                  room
);
	import ctsu_pkg::*;

	fifo_entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [FIFO_COUNT_BITS-1:0] count_q;
	logic                       pop;

	assign valid     = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign room      = (count_q <= FIFO_COUNT_BITS'(FIFO_DEPTH - 2));
	assign pop       = valid && !stall;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_ptr_q] <= '{tok: push.t0, last: !push.v1};
		if (push.v1)
			mem_q[wr_ptr_p1] <= '{tok: push.t1, last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push.v0) + FIFO_PTR_BITS'(push.v1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + FIFO_COUNT_BITS'(push.v0) + FIFO_COUNT_BITS'(push.v1)
				- FIFO_COUNT_BITS'(pop);
		end
	end

	`CTSU_ASSERT(a_count_bound, clk, arst_n, count_q <= FIFO_COUNT_BITS'(FIFO_DEPTH))
	`CTSU_ASSERT(a_pair_order, clk, arst_n, push.v1 |-> push.v0)
	`CTSU_ASSERT_NEVER(a_push_without_room, clk, arst_n, !room && push.v0)
	`CTSU_ASSERT(a_head_held, clk, arst_n, (valid && stall) |=> (valid && $stable(head)))

endmodule

// ----- rtl/core/c_subset_token_scanner_unit.sv -----
// Top level of the C subset token scanner.
// Each taken character is registered, and its tokens are registered in the output queue.
// Throughput: one character per cycle while the output queue has room; output drains one
// token per cycle unless token_stall, so a character with two tokens can stall the input.
// Reset: asynchronous active low; scanner idle, position zero, output queue empty.
module c_subset_token_scanner_unit #(
	parameter int POSITION_BITS = 32,
	parameter int LENGTH_BITS   = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  char_valid,
	output logic                                  char_stall,
	input  logic [7:0]                            char_code,
	input  logic                                  end_of_text,
	output logic                                  token_valid,
	input  logic                                  token_stall,
	output logic [ctsu_pkg::TOKEN_KIND_BITS-1:0]  token_kind,
	output logic [ctsu_pkg::TOKEN_START_BITS-1:0] token_start,
	output logic [ctsu_pkg::TOKEN_LENGTH_BITS-1:0] token_length,
	output logic                                  last_of_item
);
	import ctsu_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;
	logic        room, consume, accept;
	item_t       item;
	emit_t       emit;
	fifo_entry_t head;

	assign accept     = char_valid && !char_stall;
	assign consume    = valid_s1 && room;
	assign char_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	assign item = '{valid: consume, char_code: char_s1, end_of_text: eot_s1};

	ctsu_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.emit  (emit)
	);

	ctsu_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (emit),
		.stall (token_stall),
		.valid (token_valid),
		.head  (head),
		.room  (room)
	);

	assign token_kind   = head.tok.kind;
	assign token_start  = head.tok.start;
	assign token_length = head.tok.length;
	assign last_of_item = head.last;

endmodule
